[sv/isc_pkg.sv]
// ----------------------------------------------------------------------------
// isc_pkg: shared types for the integer stack calculator
// Request and result payloads, request and status codes, controller states.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned DEPTH_W  = 11;
  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned STATUS_W = 3;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_RD_TOP = 3'd2,
    REQ_RD_BOT = 3'd3,
    REQ_ADD    = 3'd4,
    REQ_SUB    = 3'd5,
    REQ_MUL    = 3'd6,
    REQ_DIV    = 3'd7
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_RANGE   = 3'd3,
    STAT_FEW     = 3'd4,
    STAT_DIVZERO = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CAPT,
    ST_RD_SEC,
    ST_OPER,
    ST_DIV_WAIT,
    ST_WRBACK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    req_e               req_type;
    logic signed [31:0] push_value;
    logic [POS_W-1:0]   position;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_e            status;
    depth_t             depth_now;
  } out_res_t;

endpackage

[sv/isc_divider.sv]
// ----------------------------------------------------------------------------
// isc_divider: iterative floor divider
// Restoring radix-2 division on magnitudes, one quotient bit per cycle,
// followed by a sign fixup that rounds toward minus infinity.
// ----------------------------------------------------------------------------
module isc_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  isc_pkg::word_t dividend_i,
  input  isc_pkg::word_t divisor_i,
  output logic          done_o,
  output isc_pkg::word_t quotient_o
);

  localparam int unsigned W     = isc_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             fix_q, fix_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             neg_q;
  logic [W-1:0]     dvd_q, dvs_q, rem_q, quot_q;

  logic [W-1:0]     a_mag, b_mag;
  logic [W:0]       rem_sh, diff;
  logic             qbit;
  logic [W-1:0]     rem_nx;

  assign a_mag  = dividend_i[W-1] ? (~dividend_i + W'(1)) : dividend_i;
  assign b_mag  = divisor_i[W-1]  ? (~divisor_i + W'(1))  : divisor_i;

  assign rem_sh = {rem_q, dvd_q[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign qbit   = ~diff[W];
  assign rem_nx = qbit ? diff[W-1:0] : rem_sh[W-1:0];

  always_comb begin
    busy_d = busy_q;
    fix_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        fix_d  = 1'b1;
      end
    end else if (fix_q) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fix_q  <= fix_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // dvd_q shifts the dividend out and the quotient bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= a_mag;
      dvs_q <= b_mag;
      rem_q <= '0;
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[W-2:0], qbit};
      rem_q <= rem_nx;
    end
    if (fix_q) begin
      // negative inexact quotient: -(q+1) == ~q
      if (neg_q) begin
        quot_q <= (|rem_q) ? ~dvd_q : (~dvd_q + W'(1));
      end else begin
        quot_q <= dvd_q;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

[sv/integer_stack_calculator.sv]
// ----------------------------------------------------------------------------
// integer_stack_calculator: bounded stack of signed words with arithmetic
// Stack entries live in a single-port-write, registered-read memory; a small
// controller reads, computes and writes back one request at a time.
// ----------------------------------------------------------------------------
// Push and issue errors go straight to the result; pop and reads capture
// a read; arithmetic reads two entries and, but for divide by zero, writes
// back (the divider runs one bit per cycle). A new request is accepted the
// cycle after the result register is loaded, even while it still stalls.
// Reset clears the controller, fill count and result valid; stack memory
// is not cleared (only entries below the fill count are ever read).
module integer_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  isc_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output isc_pkg::out_res_t out_res_o
);

  localparam int unsigned W    = isc_pkg::WORD_W;
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW   = isc_pkg::POS_W;
  localparam int unsigned CMPW = (CW > PW) ? CW : PW;
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  isc_pkg::state_e   state_q, state_d;
  isc_pkg::in_req_t  req_q, req_d;
  logic [CW-1:0]     fill_q, fill_d;
  isc_pkg::word_t    top_q, top_d;
  isc_pkg::word_t    val_q, val_d;
  isc_pkg::status_e  res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  isc_pkg::out_res_t out_q, out_d;

  isc_pkg::status_e  issue_st;
  logic [CMPW-1:0]   fill_ext, pos_ext, top_idx;
  logic [CW-1:0]     fill_m1, fill_m2;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  isc_pkg::word_t    mem_wdata;
  isc_pkg::word_t    rdata_q;
  isc_pkg::word_t    mem [STACK_DEPTH];

  logic              div_start, div_done;
  isc_pkg::word_t    div_quot;

  assign fill_ext = CMPW'(fill_q);
  assign pos_ext  = CMPW'(req_q.position);
  assign top_idx  = fill_ext - CMPW'(1) - pos_ext;
  assign fill_m1  = fill_q - CW'(1);
  assign fill_m2  = fill_q - CW'(2);

  always_comb begin
    case (req_q.req_type)
      isc_pkg::REQ_PUSH:
        issue_st = (fill_q == FULL_CNT) ? isc_pkg::STAT_FULL : isc_pkg::STAT_OK;
      isc_pkg::REQ_POP:
        issue_st = (fill_q == '0) ? isc_pkg::STAT_EMPTY : isc_pkg::STAT_OK;
      isc_pkg::REQ_RD_TOP, isc_pkg::REQ_RD_BOT:
        issue_st = (pos_ext >= fill_ext) ? isc_pkg::STAT_RANGE : isc_pkg::STAT_OK;
      default:
        issue_st = (fill_q < CW'(2)) ? isc_pkg::STAT_FEW : isc_pkg::STAT_OK;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      isc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = isc_pkg::ST_ISSUE;
      end
      isc_pkg::ST_ISSUE: begin
        if (issue_st != isc_pkg::STAT_OK) begin
          state_d = isc_pkg::ST_FINISH;
        end else begin
          case (req_q.req_type)
            isc_pkg::REQ_PUSH: state_d = isc_pkg::ST_FINISH;
            isc_pkg::REQ_POP, isc_pkg::REQ_RD_TOP, isc_pkg::REQ_RD_BOT:
              state_d = isc_pkg::ST_CAPT;
            default: state_d = isc_pkg::ST_RD_SEC;
          endcase
        end
      end
      isc_pkg::ST_CAPT:   state_d = isc_pkg::ST_FINISH;
      isc_pkg::ST_RD_SEC: state_d = isc_pkg::ST_OPER;
      isc_pkg::ST_OPER: begin
        if (req_q.req_type != isc_pkg::REQ_DIV) begin
          state_d = isc_pkg::ST_WRBACK;
        end else if (top_q == '0) begin
          state_d = isc_pkg::ST_FINISH;
        end else begin
          state_d = isc_pkg::ST_DIV_WAIT;
        end
      end
      isc_pkg::ST_DIV_WAIT: begin
        if (div_done) state_d = isc_pkg::ST_WRBACK;
      end
      isc_pkg::ST_WRBACK: state_d = isc_pkg::ST_FINISH;
      isc_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) state_d = isc_pkg::ST_IDLE;
      end
      default: state_d = isc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d       = req_q;
    fill_d      = fill_q;
    top_d       = top_q;
    val_d       = val_q;
    res_st_d    = res_st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = fill_m2[AW-1:0];
    mem_raddr   = fill_m1[AW-1:0];
    mem_wdata   = val_q;
    div_start   = 1'b0;

    case (state_q)
      isc_pkg::ST_IDLE: begin
        if (in_valid_i) req_d = in_req_i;
      end
      isc_pkg::ST_ISSUE: begin
        res_st_d = issue_st;
        val_d    = '0;
        if (issue_st == isc_pkg::STAT_OK) begin
          case (req_q.req_type)
            isc_pkg::REQ_PUSH: begin
              mem_we    = 1'b1;
              mem_waddr = fill_q[AW-1:0];
              mem_wdata = isc_pkg::word_t'(req_q.push_value);
              fill_d    = fill_q + CW'(1);
            end
            isc_pkg::REQ_POP: begin
              mem_re = 1'b1;
              fill_d = fill_m1;
            end
            isc_pkg::REQ_RD_TOP: begin
              mem_re    = 1'b1;
              mem_raddr = top_idx[AW-1:0];
            end
            isc_pkg::REQ_RD_BOT: begin
              mem_re    = 1'b1;
              mem_raddr = pos_ext[AW-1:0];
            end
            default: mem_re = 1'b1;
          endcase
        end
      end
      isc_pkg::ST_CAPT: val_d = rdata_q;
      isc_pkg::ST_RD_SEC: begin
        top_d     = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = fill_m2[AW-1:0];
      end
      isc_pkg::ST_OPER: begin
        // rdata_q holds the second entry here
        case (req_q.req_type)
          isc_pkg::REQ_ADD: val_d = rdata_q + top_q;
          isc_pkg::REQ_SUB: val_d = rdata_q - top_q;
          isc_pkg::REQ_MUL: val_d = rdata_q * top_q;
          default: begin
            if (top_q == '0) begin
              res_st_d = isc_pkg::STAT_DIVZERO;
              fill_d   = fill_m2;
            end else begin
              div_start = 1'b1;
            end
          end
        endcase
      end
      isc_pkg::ST_DIV_WAIT: begin
        if (div_done) val_d = div_quot;
      end
      isc_pkg::ST_WRBACK: begin
        mem_we = 1'b1;
        fill_d = fill_m1;
      end
      isc_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.read_value = val_q;
          out_d.status    = res_st_q;
          out_d.depth_now = isc_pkg::depth_t'(fill_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isc_pkg::ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    top_q    <= top_d;
    val_q    <= val_d;
    res_st_q <= res_st_d;
    out_q    <= out_d;
  end

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  isc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rdata_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_stall_o  = (state_q != isc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

[sv/isc_checker.sv]
// ----------------------------------------------------------------------------
// isc_checker: port-level checks for the integer stack calculator
// Watches the result channel and relates status codes to value and depth; checks requests do not overlap.
// ----------------------------------------------------------------------------
module isc_checker #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input isc_pkg::out_res_t out_res_o
);

  localparam isc_pkg::depth_t FULL_DEPTH = isc_pkg::depth_t'(STACK_DEPTH);

  logic in_fire;
  assign in_fire = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.status != isc_pkg::STAT_OK) |-> out_res_o.read_value == '0)
    else $error("error result carries a nonzero value");

  a_full_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.status == isc_pkg::STAT_FULL) |->
      out_res_o.depth_now == FULL_DEPTH)
    else $error("full status with depth below capacity");

  a_empty_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.status == isc_pkg::STAT_EMPTY) |-> out_res_o.depth_now == '0)
    else $error("empty status with entries held");

  // a request is only taken once the previous one has reached the result side
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("request accepted while another is in flight");

endmodule

bind integer_stack_calculator isc_checker #(.STACK_DEPTH(STACK_DEPTH)) u_isc_checker (.*);

[tb/integer_stack_calculator_test.sv]
// ----------------------------------------------------------------------------
// integer_stack_calculator_test: self-checking bench for the stack calculator
// Queued requests go through a valid/stall driver. Each accepted request is
// run through a local stack predictor, and every result is checked field by
// field against the oldest prediction. Directed corner cases come first, then
// random RPN sequences under varying idle/stall pressure, then a fill to full and a last random phase.
// ----------------------------------------------------------------------------
module integer_stack_calculator_test;

  localparam int unsigned STACK_DEPTH  = 1024;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef logic [isc_pkg::POS_W-1:0] pos_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  isc_pkg::in_req_t  in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  isc_pkg::out_res_t out_res_o;

  isc_pkg::in_req_t  pending_reqs[$];
  isc_pkg::out_res_t results_due[$];
  isc_pkg::out_res_t res_head;

  // predictor state
  logic signed [31:0] stack_mem [STACK_DEPTH];
  int unsigned        stack_fill = 0;

  // generator-side depth estimate, resynced after every drain
  int unsigned gen_depth    = 0;
  int unsigned n_queued     = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned mismatches   = 0;
  logic        hold_go      = 1'b0;
  logic        rx_hold      = 1'b0;

  integer_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic isc_pkg::out_res_t apply_request(isc_pkg::in_req_t r);
    isc_pkg::out_res_t  res;
    logic signed [31:0] top_w;
    logic signed [31:0] sec_w;
    longint             quo;
    longint             rem;
    res.read_value = '0;
    res.status     = isc_pkg::STAT_OK;
    case (r.req_type)
      isc_pkg::REQ_PUSH: begin
        if (stack_fill >= STACK_DEPTH) res.status = isc_pkg::STAT_FULL;
        else begin
          stack_mem[stack_fill] = r.push_value;
          stack_fill++;
        end
      end
      isc_pkg::REQ_POP: begin
        if (stack_fill == 0) res.status = isc_pkg::STAT_EMPTY;
        else begin
          stack_fill--;
          res.read_value = stack_mem[stack_fill];
        end
      end
      isc_pkg::REQ_RD_TOP: begin
        if (r.position >= stack_fill) res.status = isc_pkg::STAT_RANGE;
        else res.read_value = stack_mem[stack_fill - 1 - r.position];
      end
      isc_pkg::REQ_RD_BOT: begin
        if (r.position >= stack_fill) res.status = isc_pkg::STAT_RANGE;
        else res.read_value = stack_mem[r.position];
      end
      default: begin
        if (stack_fill < 2) res.status = isc_pkg::STAT_FEW;
        else begin
          top_w = stack_mem[stack_fill - 1];
          sec_w = stack_mem[stack_fill - 2];
          stack_fill -= 2;
          case (r.req_type)
            isc_pkg::REQ_ADD: res.read_value = sec_w + top_w;
            isc_pkg::REQ_SUB: res.read_value = sec_w - top_w;
            isc_pkg::REQ_MUL: res.read_value = sec_w * top_w;
            default: begin
              if (top_w == 0) res.status = isc_pkg::STAT_DIVZERO;
              else begin
                // 64-bit math: min / -1 lands on 2^31 and wraps when truncated
                quo = longint'(sec_w) / longint'(top_w);
                rem = longint'(sec_w) % longint'(top_w);
                if (rem != 0 && ((rem < 0) != (top_w < 0))) quo--;
                res.read_value = quo[31:0];
              end
            end
          endcase
          // divide by zero drops both operands and pushes nothing
          if (res.status == isc_pkg::STAT_OK) begin
            stack_mem[stack_fill] = res.read_value;
            stack_fill++;
          end
        end
      end
    endcase
    res.depth_now = isc_pkg::depth_t'(stack_fill);
    return res;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) results_due.push_back(apply_request(in_req_i));
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i   <= pending_reqs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %0d status %0d depth %0d",
                     out_res_o.read_value, out_res_o.status, out_res_o.depth_now);
        end else begin
          res_head = results_due.pop_front();
          if (out_res_o.read_value !== res_head.read_value ||
              out_res_o.status !== res_head.status ||
              out_res_o.depth_now !== res_head.depth_now) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %0d status %0d depth %0d, got %0d %0d %0d",
                       res_head.read_value, res_head.status, res_head.depth_now,
                       out_res_o.read_value, out_res_o.status, out_res_o.depth_now);
          end
        end
      end
      out_stall_i <= rx_hold || ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic put(isc_pkg::req_e kind, logic signed [31:0] val, pos_t pos);
    isc_pkg::in_req_t r;
    r.req_type   = kind;
    r.push_value = val;
    r.position   = pos;
    pending_reqs.push_back(r);
    n_queued++;
    case (kind)
      isc_pkg::REQ_PUSH:   if (gen_depth < STACK_DEPTH) gen_depth++;
      isc_pkg::REQ_POP:    if (gen_depth > 0) gen_depth--;
      isc_pkg::REQ_RD_TOP, isc_pkg::REQ_RD_BOT: ;
      default:             if (gen_depth >= 2) gen_depth--;
    endcase
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sd0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'sh8000_0000;
      4:       return 32'sh7fff_ffff;
      5, 6:    return int'($urandom_range(0, 40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  // mostly in range or just past the fill, sometimes anywhere
  function automatic pos_t read_pos();
    int unsigned lim;
    lim = (gen_depth > STACK_DEPTH - 1) ? STACK_DEPTH - 1 : gen_depth;
    if ($urandom_range(0, 3) == 0) return pos_t'($urandom);
    return pos_t'($urandom_range(0, lim));
  endfunction

  function automatic isc_pkg::req_e pick_arith();
    return isc_pkg::req_e'($urandom_range(isc_pkg::REQ_ADD, isc_pkg::REQ_DIV));
  endfunction

  task automatic gen_mixed(int unsigned n);
    int unsigned start;
    int unsigned r;
    start = n_queued;
    while (n_queued - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        put(isc_pkg::REQ_PUSH, pick_word(), pos_t'($urandom));
        put(isc_pkg::REQ_PUSH, pick_word(), pos_t'($urandom));
        put(pick_arith(), $urandom, pos_t'($urandom));
      end else if (r < 60) begin
        put(isc_pkg::REQ_PUSH, pick_word(), pos_t'($urandom));
        put(pick_arith(), $urandom, pos_t'($urandom));
      end else if (r < 65) begin
        put(isc_pkg::REQ_PUSH, 32'sd0, pos_t'($urandom));
        put(isc_pkg::REQ_DIV, $urandom, pos_t'($urandom));
      end else if (r < 75) begin
        put($urandom_range(0, 1) ? isc_pkg::REQ_RD_TOP : isc_pkg::REQ_RD_BOT,
            $urandom, read_pos());
      end else if (r < 85) begin
        put(isc_pkg::REQ_POP, $urandom, pos_t'($urandom));
      end else if (r < 90) begin
        put(pick_arith(), $urandom, pos_t'($urandom));
      end else begin
        put(isc_pkg::req_e'($urandom_range(0, 7)), $urandom, pos_t'($urandom));
      end
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || results_due.size() != 0);
    gen_depth = stack_fill;
  endtask

  task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned n);
    @(negedge clk_i);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    gen_mixed(n);
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner cases on an empty, then shallow, stack
    put(isc_pkg::REQ_POP, 32'sd0, '0);
    put(isc_pkg::REQ_RD_TOP, 32'sd0, '0);
    put(isc_pkg::REQ_RD_BOT, 32'sd0, '1);
    put(isc_pkg::REQ_ADD, 32'sd0, '0);
    put(isc_pkg::REQ_PUSH, 32'sh7fff_ffff, '0);
    put(isc_pkg::REQ_MUL, 32'sd0, '0);
    put(isc_pkg::REQ_PUSH, 32'sd1, '0);
    put(isc_pkg::REQ_ADD, 32'sd0, '0);               // wraps to the minimum
    put(isc_pkg::REQ_PUSH, -32'sd1, '0);
    put(isc_pkg::REQ_DIV, 32'sd0, '0);               // minimum over minus one
    put(isc_pkg::REQ_RD_TOP, 32'sd0, '0);
    put(isc_pkg::REQ_RD_BOT, 32'sd0, '0);
    put(isc_pkg::REQ_RD_TOP, 32'sd0, 10'd1);
    put(isc_pkg::REQ_PUSH, 32'sd0, '0);
    put(isc_pkg::REQ_DIV, 32'sd0, '0);               // divide by zero, stack empties
    put(isc_pkg::REQ_PUSH, -32'sd7, '0);
    put(isc_pkg::REQ_PUSH, 32'sd2, '0);
    put(isc_pkg::REQ_DIV, 32'sd0, '0);               // inexact negative rounds down
    put(isc_pkg::REQ_PUSH, 32'sd7, '0);
    put(isc_pkg::REQ_PUSH, -32'sd2, '0);
    put(isc_pkg::REQ_DIV, 32'sd0, '0);
    put(isc_pkg::REQ_SUB, 32'sd0, '0);
    put(isc_pkg::REQ_PUSH, 32'sh8000_0000, '0);
    put(isc_pkg::REQ_MUL, 32'sd0, '0);
    put(isc_pkg::REQ_POP, 32'sd0, '0);
    wait_drain();

    hold_go = 1'b1;
    run_phase(0, 0, 100);
    run_phase(78, 0, 80);
    run_phase(0, 78, 80);
    run_phase(18, 18, 80);

    // fill to full, probe both ends, push past full
    @(negedge clk_i);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (gen_depth < STACK_DEPTH) begin
      if ($urandom_range(0, 9) == 0)
        put($urandom_range(0, 1) ? isc_pkg::REQ_RD_TOP : isc_pkg::REQ_RD_BOT,
            $urandom, read_pos());
      else
        put(isc_pkg::REQ_PUSH, pick_word(), pos_t'($urandom));
    end
    put(isc_pkg::REQ_PUSH, pick_word(), '0);
    put(isc_pkg::REQ_RD_TOP, 32'sd0, '1);
    put(isc_pkg::REQ_RD_BOT, 32'sd0, '1);
    put(isc_pkg::REQ_MUL, 32'sd0, '0);
    put(isc_pkg::REQ_PUSH, pick_word(), '0);
    put(isc_pkg::REQ_PUSH, pick_word(), '0);
    put(isc_pkg::REQ_POP, 32'sd0, '0);
    wait_drain();
    run_phase(18, 18, 40);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("** integer_stack_calculator: PASSED **");
    end else begin
      $display("** integer_stack_calculator: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** integer_stack_calculator: FAILED **");
    $finish;
  end

endmodule
